// ----- hdl/bmp_pkg.sv -----
// Shared types and constants of the bitmap stream decoder.
`timescale 1ns / 1ps
package bmp_pkg;

  localparam int unsigned MAX_WIDTH       = 4096;
  localparam int unsigned MAX_HEIGHT      = 4096;
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_M = 8'h4d;
  localparam logic [31:0] HDR_LAST_BYTE = 32'd53;
  localparam logic [31:0] PAL_LAST_BYTE = 32'd54 + 32'(4 * PALETTE_ENTRIES) - 32'd1;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PALETTE = 3'd1,
    PH_SKIP    = 3'd2,
    PH_PIXELS  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_MAGIC      = 3'd1,
    ERR_COMPRESSED = 3'd2,
    ERR_NEG_HEIGHT = 3'd3,
    ERR_PLANES     = 3'd4,
    ERR_DEPTH      = 3'd5,
    ERR_TOO_LARGE  = 3'd6
  } err_t;

  localparam logic CFG_OUTPUT_FORMAT = 1'b0;
  localparam logic CFG_HEADER_ONLY   = 1'b1;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic        from_pal;   // colour comes from the palette read
    logic [23:0] rgb;        // direct colour when not from palette
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] width;
    logic [12:0] height;
    logic        last;
  } res_t;

  function automatic logic [23:0] fmt_colour(input logic [23:0] rgb, input logic f15);
    if (f15) return {8'h00, 1'b1, rgb[7:3], rgb[15:11], rgb[23:19]};
    return rgb;
  endfunction

  function automatic logic [12:0] sat13(input logic [31:0] v);
    return (v > 32'd8191) ? 13'h1fff : v[12:0];
  endfunction

endpackage

// ----- hdl/bmp_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bmp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- hdl/bmp_parser.sv -----
// Byte parser: header fields, palette writes, pixel walk and verdict.
`timescale 1ns / 1ps
module bmp_parser
  import bmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,       // accepted byte this cycle
  input  logic [7:0]        data_byte,
  input  logic              sof,
  input  logic              header_only,
  output logic              res_valid,
  output res_t              res,
  output logic              pal_we,
  output logic [PAL_AW-1:0] pal_waddr,
  output logic [23:0]       pal_wdata,
  output logic [PAL_AW-1:0] pal_raddr
);
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] magic_r, magic_nxt, planes_r, planes_nxt, depth_r, depth_nxt;
  logic [31:0] offs_r, offs_nxt, wid_r, wid_nxt, hgt_r, hgt_nxt, comp_r, comp_nxt;
  logic [14:0] rbc_r, rbc_nxt;
  logic [11:0] col_r, col_nxt, row_r, row_nxt;
  logic [15:0] pend_r, pend_nxt;
  // Row geometry, registered once at the verdict.
  logic [14:0] rowlen_r, rowlen_nxt, rowpad_r, rowpad_nxt;
  logic        bpp3_r, bpp3_nxt;
  logic [1:0]  k_r, k_nxt;   // colour byte phase inside a 24-bit pixel

  logic [31:0] cur, pa, rel;
  logic [2:0]  err;
  logic        do_verdict, do_pixel;
  logic [31:0] wb;
  logic [14:0] rbc1;

  assign pa = sof ? 32'd0 : pos_r;

  always_comb begin
    err = ERR_NONE;
    if (magic_r[7:0] != MAGIC_B || magic_r[15:8] != MAGIC_M) err = ERR_MAGIC;
    else if (comp_r != 32'd0) err = ERR_COMPRESSED;
    else if (hgt_r[31]) err = ERR_NEG_HEIGHT;
    else if (planes_r != 16'd1) err = ERR_PLANES;
    else if (depth_r != 16'd8 && depth_r != 16'd24) err = ERR_DEPTH;
    else if (wid_r > 32'(MAX_WIDTH) || hgt_r > 32'(MAX_HEIGHT)) err = ERR_TOO_LARGE;
  end

  always_comb begin
    phase_t ph;
    ph = sof ? PH_HEADER : phase_r;
    cur = pa;
    rel = cur - 32'd54;
    pos_nxt = pos_r; magic_nxt = magic_r; planes_nxt = planes_r; depth_nxt = depth_r;
    offs_nxt = offs_r; wid_nxt = wid_r; hgt_nxt = hgt_r; comp_nxt = comp_r;
    rbc_nxt = rbc_r; col_nxt = col_r; row_nxt = row_r; pend_nxt = pend_r;
    rowlen_nxt = rowlen_r; rowpad_nxt = rowpad_r; bpp3_nxt = bpp3_r; k_nxt = k_r;
    phase_nxt = phase_r;
    res_valid = 1'b0; res = '0; do_verdict = 1'b0; do_pixel = 1'b0;
    pal_we = 1'b0; pal_waddr = rel[PAL_AW+1:2];
    pal_wdata = {data_byte, pend_r}; pal_raddr = data_byte[PAL_AW-1:0];
    wb = 32'd0; rbc1 = 15'd0;
    if (step) begin
      if (sof) begin
        magic_nxt = '0; planes_nxt = '0; depth_nxt = '0; offs_nxt = '0; wid_nxt = '0;
        hgt_nxt = '0; comp_nxt = '0; rbc_nxt = '0; col_nxt = '0; row_nxt = '0;
        pend_nxt = '0; k_nxt = '0;
      end
      pos_nxt = (pa == 32'hffff_ffff) ? pa : pa + 32'd1;
      phase_nxt = ph;
      unique case (ph)
        PH_HEADER: begin
          case (cur)
            32'd0:  magic_nxt[7:0]   = data_byte;
            32'd1:  magic_nxt[15:8]  = data_byte;
            32'd10: offs_nxt[7:0]    = data_byte;
            32'd11: offs_nxt[15:8]   = data_byte;
            32'd12: offs_nxt[23:16]  = data_byte;
            32'd13: offs_nxt[31:24]  = data_byte;
            32'd18: wid_nxt[7:0]     = data_byte;
            32'd19: wid_nxt[15:8]    = data_byte;
            32'd20: wid_nxt[23:16]   = data_byte;
            32'd21: wid_nxt[31:24]   = data_byte;
            32'd22: hgt_nxt[7:0]     = data_byte;
            32'd23: hgt_nxt[15:8]    = data_byte;
            32'd24: hgt_nxt[23:16]   = data_byte;
            32'd25: hgt_nxt[31:24]   = data_byte;
            32'd26: planes_nxt[7:0]  = data_byte;
            32'd27: planes_nxt[15:8] = data_byte;
            32'd28: depth_nxt[7:0]   = data_byte;
            32'd29: depth_nxt[15:8]  = data_byte;
            32'd30: comp_nxt[7:0]    = data_byte;
            32'd31: comp_nxt[15:8]   = data_byte;
            32'd32: comp_nxt[23:16]  = data_byte;
            32'd33: comp_nxt[31:24]  = data_byte;
            default: ;
          endcase
          if (cur == HDR_LAST_BYTE) begin
            if (depth_r == 16'd4 || depth_r == 16'd8) phase_nxt = PH_PALETTE;
            else do_verdict = 1'b1;
          end
        end
        PH_PALETTE: begin
          case (rel[1:0])
            2'd0: pend_nxt = {8'h00, data_byte};
            2'd1: pend_nxt = {data_byte, pend_r[7:0]};
            2'd2: pal_we = 1'b1;
            default: ;
          endcase
          if (cur >= PAL_LAST_BYTE) begin
            pend_nxt = '0;
            do_verdict = 1'b1;
          end
        end
        PH_SKIP: begin
          if (cur >= offs_r) begin
            phase_nxt = PH_PIXELS;
            do_pixel = 1'b1;
          end
        end
        PH_PIXELS: do_pixel = 1'b1;
        default: ;
      endcase

      if (do_verdict) begin
        res_valid = 1'b1;
        res.kind = (err != ERR_NONE) ? KIND_REJECT : KIND_ACCEPT;
        res.err = err;
        res.width = sat13(wid_r);
        res.height = sat13(hgt_r);
        // Width is at most MAX_WIDTH on the pixel path, so 15 bits hold row bytes.
        bpp3_nxt = (depth_r == 16'd24);
        wb = (depth_r == 16'd24) ? 32'(wid_r[13:0]) * 32'd3 : wid_r;
        rowlen_nxt = wb[14:0];
        rowpad_nxt = 15'((wb + 32'd3) & ~32'd3);
        if (err != ERR_NONE || header_only || wid_r == 32'd0 || hgt_r == 32'd0)
          phase_nxt = PH_DONE;
        else if (offs_r <= cur + 32'd1) phase_nxt = PH_PIXELS;
        else phase_nxt = PH_SKIP;
      end

      if (do_pixel) begin
        res.width = sat13(wid_r);
        res.height = sat13(hgt_r);
        res.x = col_r;
        res.y = 12'(hgt_r[11:0] - 12'd1 - row_r);
        res.last = (32'(row_r) + 32'd1 == hgt_r) && (32'(col_r) + 32'd1 == wid_r);
        res.kind = KIND_PIXEL;
        if (rbc_r < rowlen_r) begin
          if (!bpp3_r) begin
            res.from_pal = 1'b1;
            res_valid = 1'b1;
          end else begin
            case (k_r)
              2'd0: begin pend_nxt = {8'h00, data_byte}; k_nxt = 2'd1; end
              2'd1: begin pend_nxt = {data_byte, pend_r[7:0]}; k_nxt = 2'd2; end
              default: begin
                res.rgb = {data_byte, pend_r};
                res_valid = 1'b1;
                k_nxt = 2'd0;
              end
            endcase
          end
          if (res_valid) begin
            col_nxt = col_r + 12'd1;
            if (res.last) phase_nxt = PH_DONE;
          end
        end
        rbc1 = rbc_r + 15'd1;
        rbc_nxt = rbc1;
        if (rbc1 >= rowpad_r) begin
          rbc_nxt = '0; col_nxt = '0; k_nxt = '0;
          row_nxt = row_r + 12'd1;
          if (32'(row_r) + 32'd1 >= hgt_r) phase_nxt = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; pos_r <= '0; magic_r <= '0; planes_r <= '0; depth_r <= '0;
      offs_r <= '0; wid_r <= '0; hgt_r <= '0; comp_r <= '0; rbc_r <= '0; col_r <= '0;
      row_r <= '0; pend_r <= '0; rowlen_r <= '0; rowpad_r <= 15'd4; bpp3_r <= 1'b0;
      k_r <= '0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; magic_r <= magic_nxt;
      planes_r <= planes_nxt; depth_r <= depth_nxt; offs_r <= offs_nxt;
      wid_r <= wid_nxt; hgt_r <= hgt_nxt; comp_r <= comp_nxt; rbc_r <= rbc_nxt;
      col_r <= col_nxt; row_r <= row_nxt; pend_r <= pend_nxt; rowlen_r <= rowlen_nxt;
      rowpad_r <= rowpad_nxt; bpp3_r <= bpp3_nxt; k_r <= k_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pal_only_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |-> step) else $error("palette write without a byte");
  a_done_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !sof && phase_r == PH_DONE) |-> !res_valid)
    else $error("result after done");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXELS) |-> (rbc_r < rowpad_r)) else $error("row counter overrun");
`endif
endmodule

// ----- hdl/bmp_stream_pixel_decoder.sv -----
// Top level of the bitmap stream pixel decoder.
`timescale 1ns / 1ps
// Bitmap stream pixel decoder.
// in_ channel: one file byte per item; in_tuser marks the first byte of a
//   file and restarts the parser (registers and palette kept).
// out_ channel: zero or one item per input byte: the header verdict
//   (accepted or rejected with an error code) and then one item per pixel,
//   with column, top-down line index and last-pixel flag.
// cfg_ port: index 0 selects 24-bit or 15-bit colour, index 1 stops after
//   the header verdict. Write only while idle.
// Throughput: one byte per cycle while in_tready is high. The parser updates
//   its counters and issues the palette read in the byte's cycle; the palette
//   RAM returns data in the next cycle beside the stage 1 register, and the
//   formatted result is then registered into the output queue.
// A two-entry skid queue behind the palette read keeps the input flowing
//   while the receiver stalls; in_tready drops when it could overflow.
// Reset clears the parser and the registers; the palette is undefined
//   until a palette is loaded by a file.
module bmp_stream_pixel_decoder
  import bmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // error_code, pixel_value, pixel_x, line_y,
                                  // image_width, image_height, last_pixel
  output logic [1:0]  out_tuser,  // result_kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);
  logic fmt_r, hdr_only_r;
  logic step;
  logic p_valid;
  res_t p_res;
  logic pal_we;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [23:0] pal_wdata, pal_rdata;

  // Stage 1: result waiting on palette data.
  logic s1_v_r;
  res_t s1_r;
  // Output queue of two entries.
  logic [1:0] q_cnt_r;
  logic [77:0] qd0_r, qd1_r;
  logic [1:0]  qu0_r, qu1_r;
  logic [77:0] s1_data;
  logic [23:0] s1_rgb;
  logic push, pop;
  logic to_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0; hdr_only_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_FORMAT: fmt_r <= cfg_wdata;
        CFG_HEADER_ONLY:   hdr_only_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept while stage 1 plus queue fits in the two queue slots.
  assign in_tready = (32'(q_cnt_r) + 32'(s1_v_r)) < 32'd2 ||
                     (out_tready && q_cnt_r != 2'd0 && !(s1_v_r && q_cnt_r == 2'd2));
  assign step = in_tvalid && in_tready;

  bmp_parser u_parser (
    .clk, .rst_n, .step, .data_byte(in_tdata), .sof(in_tuser),
    .header_only(hdr_only_r), .res_valid(p_valid), .res(p_res),
    .pal_we, .pal_waddr, .pal_wdata, .pal_raddr
  );

  bmp_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .re(step), .raddr(pal_raddr), .rdata(pal_rdata)
  );

  assign s1_rgb  = fmt_colour(s1_r.from_pal ? pal_rdata : s1_r.rgb, fmt_r);
  assign s1_data = {s1_r.last, s1_r.height, s1_r.width, s1_r.y, s1_r.x,
                    (s1_r.kind == KIND_PIXEL) ? s1_rgb : 24'd0, s1_r.err};
  assign push = s1_v_r;
  assign pop  = out_tvalid && out_tready;
  // New item lands at the head when the queue is empty or drains to empty.
  assign to_head = (q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; q_cnt_r <= '0;
    end else begin
      s1_v_r <= p_valid;
      if (push && !pop) q_cnt_r <= q_cnt_r + 2'd1;
      else if (!push && pop) q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= p_res;
    if (push && to_head) begin
      qd0_r <= s1_data; qu0_r <= s1_r.kind;
    end else if (pop) begin
      qd0_r <= qd1_r; qu0_r <= qu1_r;
    end
    if (push && !to_head) begin
      qd1_r <= s1_data; qu1_r <= s1_r.kind;
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {2'b00, qd0_r};
  assign out_tuser  = qu0_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2 && s1_v_r) |-> pop) else $error("output queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("queue count out of range");
  a_push_follows: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid |=> s1_v_r) else $error("lost result in stage 1");
`endif
endmodule

// ----- dv/bmp_stream_pixel_decoder_test.sv -----
// Testbench of the bitmap stream pixel decoder: built files, own decoder model, result checks.
`timescale 1ns / 1ps
module bmp_stream_pixel_decoder_test;
  import bmp_pkg::*;

  // Decoded result as the checker sees it, one per out_ item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [23:0] val;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic        last;
  } bmp_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_wdata = 1'b0;

  bmp_stream_pixel_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Decoder state mirrored by the testbench.
  logic [31:0] byte_pos;
  logic [63:0] hdr_word [4];
  logic [23:0] palette [256];
  phase_t      phase;
  logic [31:0] row_bytes, col_cnt, row_cnt, partial_rgb;
  logic        fmt15, stop_after_hdr;

  bmp_res_t    pending_results [$];
  logic [7:0]  file_q [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  bit          tx_free = 0;      // sender offers items back to back
  bit          rx_free = 0;      // receiver never stalls
  bit          hold_req = 0;     // ask the receiver for a long hold-off

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void restart_parse();
    byte_pos = 0;
    foreach (hdr_word[i]) hdr_word[i] = 64'd0;
    phase = PH_HEADER;
    row_bytes = 0;
    col_cnt = 0;
    row_cnt = 0;
    partial_rgb = 0;
  endfunction

  function automatic logic [31:0] hdr_depth();
    return {16'd0, hdr_word[0][47:32]};
  endfunction

  function automatic logic [12:0] clip13(input logic [31:0] v);
    return (v > 32'd8191) ? 13'd8191 : v[12:0];
  endfunction

  function automatic void push_result(input kind_t k, input err_t e, input logic [23:0] v,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic last);
    bmp_res_t r;
    r.kind = k;
    r.err  = e;
    r.val  = v;
    r.x    = x[11:0];
    r.y    = y[11:0];
    r.w    = clip13(hdr_word[2][31:0]);
    r.h    = clip13(hdr_word[2][63:32]);
    r.last = last;
    pending_results.push_back(r);
  endfunction

  // Checks run in a fixed order; the first one that fails names the error.
  function automatic err_t header_error();
    logic [31:0] d, wd, ht;
    d  = hdr_depth();
    wd = hdr_word[2][31:0];
    ht = hdr_word[2][63:32];
    if (hdr_word[0][7:0] != MAGIC_B || hdr_word[0][15:8] != MAGIC_M) return ERR_MAGIC;
    if (hdr_word[3][31:0] != 32'd0) return ERR_COMPRESSED;
    if (ht[31]) return ERR_NEG_HEIGHT;
    if (hdr_word[0][31:16] != 16'd1) return ERR_PLANES;
    if (d != 32'd8 && d != 32'd24) return ERR_DEPTH;
    if (wd > MAX_WIDTH || ht > MAX_HEIGHT) return ERR_TOO_LARGE;
    return ERR_NONE;
  endfunction

  function automatic void give_verdict(input logic [31:0] cur);
    err_t e;
    e = header_error();
    push_result(e == ERR_NONE ? KIND_ACCEPT : KIND_REJECT, e, 24'd0, 0, 0, 1'b0);
    if (e != ERR_NONE || stop_after_hdr || hdr_word[2][31:0] == 0 || hdr_word[2][63:32] == 0)
      phase = PH_DONE;
    else if (hdr_word[1][31:0] <= cur + 32'd1)
      phase = PH_PIXELS;
    else
      phase = PH_SKIP;
  endfunction

  function automatic logic [23:0] format_rgb(input logic [23:0] rgb);
    if (fmt15) return {8'h00, 1'b1, rgb[7:3], rgb[15:11], rgb[23:19]};
    return rgb;
  endfunction

  // One byte of pixel data: palette index or one of three colour bytes, or padding.
  function automatic void pixel_data(input logic [7:0] b);
    logic [31:0] wd, ht, bpp, row_len, stride, k;
    logic [23:0] rgb;
    logic        ready, last;
    wd      = hdr_word[2][31:0];
    ht      = hdr_word[2][63:32];
    bpp     = (hdr_depth() == 32'd24) ? 32'd3 : 32'd1;
    row_len = wd * bpp;
    stride  = (row_len + 32'd3) & ~32'd3;
    ready   = 1'b0;
    rgb     = 24'd0;
    if (row_bytes < row_len) begin
      if (bpp == 32'd1) begin
        rgb = palette[b];
        ready = 1'b1;
      end else begin
        k = row_bytes - col_cnt * 32'd3;
        if (k == 0) partial_rgb = {24'd0, b};
        else if (k == 1) partial_rgb = partial_rgb | {16'd0, b, 8'd0};
        else begin
          rgb = {b, partial_rgb[15:0]};
          ready = 1'b1;
        end
      end
      if (ready) begin
        last = (row_cnt + 1 == ht) && (col_cnt + 1 == wd);
        push_result(KIND_PIXEL, ERR_NONE, format_rgb(rgb), col_cnt, ht - 1 - row_cnt, last);
        col_cnt++;
        if (last) phase = PH_DONE;
      end
    end
    row_bytes++;
    if (row_bytes >= stride) begin
      row_bytes = 0;
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= ht) phase = PH_DONE;
    end
  endfunction

  function automatic void place(input int slot, input int base, input logic [31:0] cur,
                                input int lo, input int n, input logic [7:0] b);
    if (cur >= lo && cur < lo + n)
      hdr_word[slot] = hdr_word[slot] | (64'(b) << (base + (cur - lo) * 8));
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic sof);
    logic [31:0] cur, rel;
    if (sof) restart_parse();
    cur = byte_pos;
    if (byte_pos != 32'hffff_ffff) byte_pos++;
    case (phase)
      PH_HEADER: begin
        place(0, 0, cur, 0, 2, b);
        place(1, 0, cur, 10, 4, b);
        place(2, 0, cur, 18, 4, b);
        place(2, 32, cur, 22, 4, b);
        place(0, 16, cur, 26, 2, b);
        place(0, 32, cur, 28, 2, b);
        place(3, 0, cur, 30, 4, b);
        if (cur == HDR_LAST_BYTE) begin
          if (hdr_depth() == 32'd4 || hdr_depth() == 32'd8) phase = PH_PALETTE;
          else give_verdict(cur);
        end
      end
      PH_PALETTE: begin
        // Entries are blue, green, red, unused.
        rel = cur - 32'd54;
        if (rel[1:0] == 2'd0) partial_rgb = {24'd0, b};
        else if (rel[1:0] == 2'd1) partial_rgb = partial_rgb | {16'd0, b, 8'd0};
        else if (rel[1:0] == 2'd2) palette[rel[9:2]] = {b, partial_rgb[15:0]};
        if (cur >= PAL_LAST_BYTE) begin
          partial_rgb = 0;
          give_verdict(cur);
        end
      end
      PH_SKIP: begin
        if (cur >= hdr_word[1][31:0]) begin
          phase = PH_PIXELS;
          pixel_data(b);
        end
      end
      PH_PIXELS: pixel_data(b);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bmp_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.err  = out_tdata[2:0];
      got.val  = out_tdata[26:3];
      got.x    = out_tdata[38:27];
      got.y    = out_tdata[50:39];
      got.w    = out_tdata[63:51];
      got.h    = out_tdata[76:64];
      got.last = out_tdata[77];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d err %0d val %h x %0d y %0d",
                   got.kind, got.err, got.val, got.x, got.y);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.err !== want.err || got.val !== want.val ||
            got.x !== want.x || got.y !== want.y || got.w !== want.w ||
            got.h !== want.h || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp kind %0d err %0d val %h x %0d y %0d w %0d h %0d last %0d",
                      " / got kind %0d err %0d val %h x %0d y %0d w %0d h %0d last %0d"},
                     want.kind, want.err, want.val, want.x, want.y, want.w, want.h,
                     want.last, got.kind, got.err, got.val, got.x, got.y, got.w, got.h,
                     got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, mostly short; a requested hold-off runs here
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_free) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    int r;
    r = $urandom_range(0, 19);
    gap = tx_free ? 0 : (r < 13) ? 0 : (r < 19) ? $urandom_range(1, 3)
                                                : $urandom_range(4, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic send_file(input bit mark);
    foreach (file_q[i]) send_byte(file_q[i], mark && i == 0);
  endtask

  // Drop valid, drain expected results, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OUTPUT_FORMAT) fmt15 = val;
    else stop_after_hdr = val;
  endtask

  function automatic void put_le(input int at, input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++) file_q[at + i] = v[8*i +: 8];
  endfunction

  // Build a file: header, palette for 4/8 bits, gap up to the offset, pixel rows, tail.
  function automatic void make_file(input logic [15:0] magic, input logic [31:0] comp,
                                    input logic [15:0] planes, input logic [15:0] depth,
                                    input logic [31:0] wd, input logic [31:0] ht,
                                    input logic [31:0] off, input int tail);
    int stride;
    file_q.delete();
    for (int i = 0; i < 54; i++) file_q.push_back(8'($urandom));
    put_le(0, 2, {16'd0, magic});
    put_le(10, 4, off);
    put_le(18, 4, wd);
    put_le(22, 4, ht);
    put_le(26, 2, {16'd0, planes});
    put_le(28, 2, {16'd0, depth});
    put_le(30, 4, comp);
    if (depth == 16'd4 || depth == 16'd8)
      for (int i = 0; i < 1024; i++) file_q.push_back(8'($urandom));
    if (off < 32'd3000)
      while (file_q.size() < off) file_q.push_back(8'($urandom));
    if (wd <= MAX_WIDTH && ht <= MAX_HEIGHT) begin
      stride = ((int'(wd) * (depth == 16'd24 ? 3 : 1)) + 3) & ~3;
      for (int i = 0; i < stride * int'(ht); i++) file_q.push_back(8'($urandom));
    end
    for (int i = 0; i < tail; i++) file_q.push_back(8'($urandom));
  endfunction

  function automatic void make_good(input logic [15:0] depth, input int wd, input int ht,
                                    input int tail);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, depth, wd, ht, depth == 16'd24 ? 54 : 1078, tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the parser takes bytes as a file even with no start mark.
  task automatic test_no_start_mark();
    make_good(24, 3, 2, 2);
    send_file(0);
  endtask

  // One or more files per header check, in check order.
  task automatic test_header_checks();
    make_file(16'h4d43, 0, 1, 24, 2, 2, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 32'h1, 1, 24, 2, 2, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 2, 32'hffff_fffe, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 2, 24, 2, 2, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 16, 2, 2, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 4097, 1, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 1, 4097, 54, 3);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 32'h7fff_ffff, 32'h7fff_0000, 54, 3);
    send_file(1);
  endtask

  // Palette image with a gap before the pixels.
  task automatic test_palette_image();
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 8, 5, 3, 1090, 4);
    send_file(1);
  endtask

  // Offset of zero, offset one past the header, and an offset far ahead.
  task automatic test_offset_cases();
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 2, 2, 0, 0);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 1, 3, 55, 0);
    send_file(1);
    make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, 3, 1, 80, 1);
    send_file(1);
  endtask

  // Zero width or height is accepted and nothing follows.
  task automatic test_empty_image();
    make_good(24, 0, 5, 6);
    send_file(1);
    make_good(24, 4, 0, 6);
    send_file(1);
  endtask

  // 15-bit colour and header-only mode, then back to the defaults.
  task automatic test_config_modes();
    write_reg(CFG_OUTPUT_FORMAT, 1'b1);
    make_good(24, 6, 2, 0);
    send_file(1);
    write_reg(CFG_HEADER_ONLY, 1'b1);
    make_good(24, 4, 2, 2);
    send_file(1);
    write_reg(CFG_HEADER_ONLY, 1'b0);
    write_reg(CFG_OUTPUT_FORMAT, 1'b0);
  endtask

  // Largest width and largest height, one line or one column each; only the
  // first pixels are sent, the next start mark ends the file.
  task automatic test_size_extremes();
    make_good(24, 4096, 1, 0);
    while (file_q.size() > 114) void'(file_q.pop_back());
    send_file(1);
    make_good(24, 1, 4096, 0);
    while (file_q.size() > 114) void'(file_q.pop_back());
    send_file(1);
  endtask

  // Hold the receiver off while bytes keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_idle();
    make_good(24, 16, 4, 0);
    tx_free = 1;
    hold_req = 1;
    send_file(1);
    tx_free = 0;
  endtask

  task automatic test_random();
    int pick, cut;
    while (bytes_sent < 2600) begin
      pick = $urandom_range(0, 17);
      if (pick < 12)
        make_file({MAGIC_M, MAGIC_B}, 0, 1, 24, $urandom_range(0, 9), $urandom_range(0, 5),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : 54,
                  $urandom_range(0, 3));
      else if (pick < 16)
        make_file(($urandom_range(0, 3) == 0) ? 16'($urandom) : {MAGIC_M, MAGIC_B},
                  ($urandom_range(0, 3) == 0) ? $urandom : 32'd0,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd24,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4),
                  $urandom_range(0, 60), $urandom_range(0, 3));
      else begin
        file_q.delete();
        repeat ($urandom_range(1, 80)) file_q.push_back(8'($urandom));
      end
      // Cut some files short; the next start mark must recover.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
      tx_free = ($urandom_range(0, 5) == 0);
      rx_free = ($urandom_range(0, 5) == 0);
      send_file($urandom_range(0, 15) != 0);
      tx_free = 0;
      rx_free = 0;
      if ($urandom_range(0, 11) == 0) write_reg(CFG_OUTPUT_FORMAT, 1'($urandom));
      if ($urandom_range(0, 19) == 0) write_reg(CFG_HEADER_ONLY, 1'($urandom));
    end
  endtask

  initial begin
    fmt15 = 1'b0;
    stop_after_hdr = 1'b0;
    foreach (palette[i]) palette[i] = 24'd0;
    restart_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_start_mark();
    test_header_checks();
    test_palette_image();
    test_offset_cases();
    test_empty_image();
    test_config_modes();
    test_size_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS bmp_stream_pixel_decoder");
    end else begin
      $display("FAIL bmp_stream_pixel_decoder");
    end
    $finish;
  end

  // Generous limit: every byte waiting out long gaps and long stalls.
  initial begin
    #40ms;
    $display("FAIL bmp_stream_pixel_decoder");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bmp_pkg.sv
hdl/bmp_ram.sv
hdl/bmp_parser.sv
hdl/bmp_stream_pixel_decoder.sv
dv/bmp_stream_pixel_decoder_test.sv
